// ===== hdl/cwt_pkg.sv =====
`timescale 1ns / 1ps

package cwt_pkg;

   // Field and register widths.
   localparam int CAND_W    = 4;
   localparam int WEIGHT_W  = 16;
   localparam int TALLY_W   = 16;
   localparam int NC_W      = 5;
   localparam int NV_W      = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int STEP_W    = 4;

   // Highest tally value; sums above it stick here.
   localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

   // Reset values of the configuration registers.
   localparam logic [NC_W-1:0] NC_RESET = 5'd16;
   localparam logic [NV_W-1:0] NV_RESET = 16'd0;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_CANDIDATES = 2'd0,
      CSR_NUM_VOTERS     = 2'd1
   } csr_idx_type;

   // Item kinds.
   typedef enum logic {
      CMD_BALLOT = 1'b0,
      CMD_EVAL   = 1'b1
   } cmd_type;

   // Steps of the control program.
   typedef enum logic [STEP_W-1:0] {
      S_IDLE       = 4'd0,
      S_DISPATCH   = 4'd1,
      S_ADD_TEST   = 4'd2,
      S_ADD_SEL    = 4'd3,
      S_ADD_WRITE  = 4'd4,
      S_ADD_NEXT   = 4'd5,
      S_ADD_END    = 4'd6,
      S_EVAL_ROW   = 4'd7,
      S_EVAL_COL   = 4'd8,
      S_EVAL_SEL   = 4'd9,
      S_EVAL_CMP   = 4'd10,
      S_EVAL_JNEXT = 4'd11,
      S_EVAL_INEXT = 4'd12,
      S_EVAL_WIN   = 4'd13,
      S_EVAL_LOSE  = 4'd14,
      S_EVAL_POST  = 4'd15
   } step_type;

   // Jump conditions a control word can test.
   typedef enum logic [3:0] {
      C_NEVER     = 4'd0,
      C_ALWAYS    = 4'd1,
      C_ACCEPT    = 4'd2,
      C_EVAL      = 4'd3,
      C_K_DONE    = 4'd4,
      C_K_SKIP    = 4'd5,
      C_I_DONE    = 4'd6,
      C_J_DONE    = 4'd7,
      C_J_IS_I    = 4'd8,
      C_TALLY_LOW = 4'd9,
      C_RSP_FREE  = 4'd10
   } cond_type;

   // Datapath actions of one control word.
   typedef struct packed {
      logic clr_idx;
      logic latch;
      logic read_k;
      logic write;
      logic inc_k;
      logic end_ballot;
      logic clr_j;
      logic read_ij;
      logic inc_i;
      logic inc_j;
      logic set_win;
      logic set_lose;
      logic post;
   } act_type;

   // Status the datapath reports to the sequencer.
   typedef struct packed {
      logic accept;
      logic is_eval;
      logic k_done;
      logic k_skip;
      logic i_done;
      logic j_done;
      logic j_is_i;
      logic tally_low;
      logic rsp_free;
   } status_type;

   // One control word: a conditional jump, a hold flag and the actions.
   typedef struct packed {
      cond_type cond;
      step_type target;
      logic     hold;
      act_type  act;
   } uword_type;

   // Control program. When the condition holds the sequencer jumps to the
   // target; otherwise it stays (hold) or moves to the next step.
   function automatic uword_type ucode(step_type s);
      uword_type w;
      w        = '0;
      w.cond   = C_NEVER;
      w.target = S_IDLE;
      case (s)
         S_IDLE: begin
            w.cond        = C_ACCEPT;
            w.target      = S_DISPATCH;
            w.hold        = 1'b1;
            w.act.clr_idx = 1'b1;
            w.act.latch   = 1'b1;
         end
         S_DISPATCH: begin
            w.cond   = C_EVAL;
            w.target = S_EVAL_ROW;
         end
         S_ADD_TEST: begin
            w.cond   = C_K_DONE;
            w.target = S_ADD_END;
         end
         S_ADD_SEL: begin
            w.cond       = C_K_SKIP;
            w.target     = S_ADD_NEXT;
            w.act.read_k = 1'b1;
         end
         S_ADD_WRITE: begin
            w.cond      = C_ALWAYS;
            w.target    = S_ADD_TEST;
            w.act.write = 1'b1;
            w.act.inc_k = 1'b1;
         end
         S_ADD_NEXT: begin
            w.cond      = C_ALWAYS;
            w.target    = S_ADD_TEST;
            w.act.inc_k = 1'b1;
         end
         S_ADD_END: begin
            w.cond           = C_ALWAYS;
            w.target         = S_IDLE;
            w.act.end_ballot = 1'b1;
         end
         S_EVAL_ROW: begin
            w.cond      = C_I_DONE;
            w.target    = S_EVAL_LOSE;
            w.act.clr_j = 1'b1;
         end
         S_EVAL_COL: begin
            w.cond   = C_J_DONE;
            w.target = S_EVAL_WIN;
         end
         S_EVAL_SEL: begin
            w.cond        = C_J_IS_I;
            w.target      = S_EVAL_JNEXT;
            w.act.read_ij = 1'b1;
         end
         S_EVAL_CMP: begin
            w.cond   = C_TALLY_LOW;
            w.target = S_EVAL_INEXT;
         end
         S_EVAL_JNEXT: begin
            w.cond      = C_ALWAYS;
            w.target    = S_EVAL_COL;
            w.act.inc_j = 1'b1;
         end
         S_EVAL_INEXT: begin
            w.cond      = C_ALWAYS;
            w.target    = S_EVAL_ROW;
            w.act.inc_i = 1'b1;
         end
         S_EVAL_WIN: begin
            w.cond        = C_ALWAYS;
            w.target      = S_EVAL_POST;
            w.act.set_win = 1'b1;
         end
         S_EVAL_LOSE: begin
            w.act.set_lose = 1'b1;
         end
         S_EVAL_POST: begin
            w.cond     = C_RSP_FREE;
            w.target   = S_IDLE;
            w.hold     = 1'b1;
            w.act.post = 1'b1;
         end
         default: begin
            w.cond   = C_ALWAYS;
            w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/cwt_seq.sv =====
`timescale 1ns / 1ps

module cwt_seq
   import cwt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output act_type    act,
   output logic       idle
);

   logic [STEP_W-1:0] pc_ff;
   logic [STEP_W-1:0] pc_in;
   uword_type         uw;
   logic              cond_met;

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // Fetch the control word, test its condition and pick the next step.
   always_comb begin
      uw = ucode(step_type'(pc_ff));
      case (uw.cond)
         C_NEVER:     cond_met = 1'b0;
         C_ALWAYS:    cond_met = 1'b1;
         C_ACCEPT:    cond_met = status.accept;
         C_EVAL:      cond_met = status.is_eval;
         C_K_DONE:    cond_met = status.k_done;
         C_K_SKIP:    cond_met = status.k_skip;
         C_I_DONE:    cond_met = status.i_done;
         C_J_DONE:    cond_met = status.j_done;
         C_J_IS_I:    cond_met = status.j_is_i;
         C_TALLY_LOW: cond_met = status.tally_low;
         C_RSP_FREE:  cond_met = status.rsp_free;
         default:     cond_met = 1'b0;
      endcase
      if (cond_met) begin
         pc_in = uw.target;
      end else if (uw.hold) begin
         pc_in = pc_ff;
      end else begin
         pc_in = pc_ff + STEP_W'(1);
      end
      act  = uw.act;
      idle = (step_type'(pc_ff) == S_IDLE);
   end

endmodule

// ===== hdl/cwt_tally_mem.sv =====
`timescale 1ns / 1ps

module cwt_tally_mem
   import cwt_pkg::*;
#(
   parameter int AW = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [TALLY_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [TALLY_W-1:0] rd_data
);

   localparam int DEPTH = 1 << AW;

   logic [TALLY_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   logic [TALLY_W-1:0] rd_q_ff;
   logic               rd_vld_ff;

   // Tally storage with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   // One valid bit per entry; an entry never written since the last clear
   // reads as zero.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else if (rd_en) begin
         rd_vld_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

// ===== hdl/condorcet_winner_tally_top.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// req      in         req_tvalid/tready     tdata: candidate, voter_weight;
//                                           tuser: command; tlast: last_of_ballot
// rsp      out        rsp_tvalid/tready     tdata: winner; tuser: has_winner
// csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// A ballot element takes each tally entry through the test, select and write (or next) steps,
// and an evaluate takes each entry that it visits through the column, select, compare and next
// steps, for the candidates in use, all through one read port.
// Reset is synchronous; it clears all tallies at once through per-entry valid bits.
// A new item is taken while an earlier result still waits on rsp; an evaluate
// holds in its last step until the rsp register is free.

module condorcet_winner_tally_top
   import cwt_pkg::*;
#(
   parameter int MAX_CANDIDATES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // Input items.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,   // [3:0] candidate, [19:4] voter_weight
   input  logic                 req_tuser,   // [0] command
   input  logic                 req_tlast,   // last_of_ballot
   // Result items.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [3:0] winner
   output logic                 rsp_tuser,   // [0] has_winner
   // Configuration writes.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   // Candidate ids are CAND_W bits wide, so no more than 2**CAND_W rows hold data.
   localparam int CAND_LIMIT = 1 << CAND_W;
   localparam int CAP        = (MAX_CANDIDATES < CAND_LIMIT) ? MAX_CANDIDATES : CAND_LIMIT;
   localparam int IDW        = $clog2(CAP);
   localparam int CW         = $clog2(CAP + 1);
   localparam bit OVER_NONE  = (MAX_CANDIDATES > CAP);

   logic [NC_W-1:0]     nc_ff;
   logic [NV_W-1:0]     nv_ff;
   logic                cmd_ff;
   logic [CAND_W-1:0]   cand_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic                last_ff;
   logic [CW-1:0]       k_ff;
   logic [CW-1:0]       i_ff;
   logic [CW-1:0]       j_ff;
   logic [CAP-1:0]      seen_ff;
   logic [CAP-1:0]      seen_in;
   logic                res_has_ff;
   logic [CAND_W-1:0]   res_win_ff;
   logic                rsp_valid_ff;
   logic                rsp_has_ff;
   logic [CAND_W-1:0]   rsp_win_ff;

   logic [NC_W-1:0]     n_act;
   logic                over_none;
   logic                accept;
   logic                rsp_free;
   logic                post_fire;
   logic                idle;
   act_type             act;
   status_type          status;
   logic [2*IDW-1:0]    rd_addr;
   logic [2*IDW-1:0]    wr_addr;
   logic [TALLY_W-1:0]  rd_data;
   logic [TALLY_W:0]    sum;
   logic [TALLY_W-1:0]  sat_sum;
   logic [NV_W-1:0]     bar;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nc_ff <= NC_RESET;
         nv_ff <= NV_RESET;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_NUM_CANDIDATES: nc_ff <= csr_data[NC_W-1:0];
            CSR_NUM_VOTERS:     nv_ff <= csr_data[NV_W-1:0];
            default: ;
         endcase
      end
   end

   // Candidate count in use, capped; when MAX_CANDIDATES exceeds the id range, counts
   // beyond the stored rows never give a winner.
   assign n_act     = (nc_ff > NC_W'(CAP)) ? NC_W'(CAP) : nc_ff;
   assign over_none = OVER_NONE && (nc_ff > NC_W'(CAP));
   assign bar       = nv_ff >> 1;

   assign req_tready = idle;
   assign accept     = req_tvalid && idle;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign post_fire  = act.post && rsp_free;

   // Status for the sequencer.
   always_comb begin
      status.accept    = accept;
      status.is_eval   = (cmd_type'(cmd_ff) == CMD_EVAL);
      status.k_done    = (NC_W'(k_ff) == n_act) || (NC_W'(cand_ff) >= n_act);
      status.k_skip    = !seen_ff[k_ff[IDW-1:0]] || (NC_W'(k_ff) == NC_W'(cand_ff));
      status.i_done    = (NC_W'(i_ff) == n_act) || over_none;
      status.j_done    = (NC_W'(j_ff) == n_act);
      status.j_is_i    = (i_ff == j_ff);
      status.tally_low = (rd_data <= bar);
      status.rsp_free  = rsp_free;
   end

   cwt_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .act    (act),
      .idle   (idle)
   );

   // Tally addressing: row is the preferred candidate, column the other.
   assign rd_addr = act.read_ij ? {i_ff[IDW-1:0], j_ff[IDW-1:0]}
                                : {k_ff[IDW-1:0], cand_ff[IDW-1:0]};
   assign wr_addr = {k_ff[IDW-1:0], cand_ff[IDW-1:0]};

   // Saturating add of the ballot weight.
   assign sum     = {1'b0, rd_data} + {1'b0, weight_ff};
   assign sat_sum = sum[TALLY_W] ? TALLY_MAX : sum[TALLY_W-1:0];

   cwt_tally_mem #(
      .AW (2 * IDW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (post_fire),
      .wr_en   (act.write),
      .wr_addr (wr_addr),
      .wr_data (sat_sum),
      .rd_en   (act.read_k || act.read_ij),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Captured item fields.
   always_ff @(posedge clock) begin
      if (act.latch && accept) begin
         cmd_ff    <= req_tuser;
         cand_ff   <= req_tdata[CAND_W-1:0];
         weight_ff <= req_tdata[CAND_W +: WEIGHT_W];
         last_ff   <= req_tlast;
      end
   end

   // Loop counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
      end else begin
         if (act.clr_idx) begin
            k_ff <= '0;
            i_ff <= '0;
         end
         if (act.inc_k) begin
            k_ff <= k_ff + CW'(1);
         end
         if (act.inc_i) begin
            i_ff <= i_ff + CW'(1);
         end
         if (act.clr_j) begin
            j_ff <= '0;
         end else if (act.inc_j) begin
            j_ff <= j_ff + CW'(1);
         end
      end
   end

   // Candidates seen in the current ballot.
   always_comb begin
      seen_in = seen_ff;
      if (act.end_ballot) begin
         if (NC_W'(cand_ff) < n_act) begin
            seen_in[cand_ff[IDW-1:0]] = 1'b1;
         end
         if (last_ff) begin
            seen_in = '0;
         end
      end
      if (post_fire) begin
         seen_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // Outcome of the search, held until the result register is free.
   always_ff @(posedge clock) begin
      if (act.set_win) begin
         res_has_ff <= 1'b1;
         res_win_ff <= CAND_W'(i_ff);
      end else if (act.set_lose) begin
         res_has_ff <= 1'b0;
         res_win_ff <= '0;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (post_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (post_fire) begin
         rsp_has_ff <= res_has_ff;
         rsp_win_ff <= res_win_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_has_ff;
   assign rsp_tdata  = {{(8 - CAND_W){1'b0}}, rsp_win_ff};

endmodule
